@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the rotation coefficient block.
// Each macro builds one labeled concurrent assertion clocked on clk with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert prop on every rising clock edge outside reset.
`define ARP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assert that cond never holds on a rising clock edge outside reset.
`define ARP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hw/rtl/arp_pkg.sv @@
// Package for the rotation coefficient block: axis codes, lane indexes, sideband type.
// No dependencies; the input interface, the top level, the checker and the testbench import it.
`timescale 1ns / 1ps

package arp_pkg;

    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] AXIS_Z = 2'd0;
    localparam logic [ACTION_W-1:0] AXIS_X = 2'd1;
    localparam logic [ACTION_W-1:0] AXIS_Y = 2'd2;

    localparam int NUM_LANES = 2;
    localparam int LANE_COS  = 0;
    localparam int LANE_SIN  = 1;

    // Sign and flag bits that ride along the datapath.
    typedef struct packed {
        logic cos_neg;
        logic sin_neg;
        logic degen;
    } arp_side_t;

endpackage

@@ hw/rtl/arp_in_if.sv @@
// Input channel of the rotation coefficient block: axis choice and one 3-D point.
// Depends on arp_pkg for the width of the axis code.
`timescale 1ns / 1ps

interface arp_in_if
    import arp_pkg::*;
#(
    parameter int COORD_WIDTH = 16
);

    logic                          valid;
    logic                          ready;
    logic [ACTION_W-1:0]           action;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (
        output valid,
        output action,
        output coord_x,
        output coord_y,
        output coord_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  coord_x,
        input  coord_y,
        input  coord_z,
        output ready
    );

endinterface

@@ hw/rtl/arp_out_if.sv @@
// Output channel of the rotation coefficient block: cosine, sine and degenerate flag.
// Standalone; the fixed-point width follows FRAC_BITS.
`timescale 1ns / 1ps

interface arp_out_if #(
    parameter int FRAC_BITS = 15
);

    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS:0]   cos_value;
    logic signed [FRAC_BITS:0]   sin_value;
    logic                        degenerate;

    modport source (
        output valid,
        output cos_value,
        output sin_value,
        output degenerate,
        input  ready
    );

    modport sink (
        input  valid,
        input  cos_value,
        input  sin_value,
        input  degenerate,
        output ready
    );

endinterface

@@ hw/rtl/axis_rotation_from_point.sv @@
// Rotation coefficient pipeline: takes a point and an axis, returns cos and sin of the
// plane rotation about that axis. Depends on arp_pkg, arp_in_if, arp_out_if, assert_macros.svh.
// Usage: the block accepts one word per clock while the output side does not stall, and
// returns one result word for each, in order. For the two coordinates a and b that the
// axis selects, each coefficient is round(|a| * 2^FRAC_BITS / sqrt(a*a + b*b)), ties away
// from zero, with exactly one saturated to 2^FRAC_BITS - 1; it comes from
// floor(a*a * 2^(2*FRAC_BITS+2) / (a*a + b*b)), built by a restoring divider that resolves
// one quotient bit per stage, followed by an integer square root that resolves one root
// bit per stage; these two chains set the latency. When both selected coordinates are
// zero, or the axis code is three, the result is zero with degenerate set. A stall at the
// output freezes the whole pipeline, and input ready follows it in the same cycle. The
// interface instances must be built with the same COORD_WIDTH and FRAC_BITS as the block.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module axis_rotation_from_point
    import arp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 15
)(
    input logic       clk,
    input logic       rst_n,
    arp_in_if.sink    point,
    arp_out_if.source coeff
);

    localparam int MW      = COORD_WIDTH;        // coordinate magnitude
    localparam int SW      = 2 * COORD_WIDTH;    // squares and their sum
    localparam int QW      = 2 * FRAC_BITS + 3;  // quotient bits
    localparam int NR      = FRAC_BITS + 2;      // root bits
    localparam int RW      = NR + 2;             // root remainder
    localparam int CAW     = RW + 2;             // root candidate
    localparam int DW      = 2 * NR;             // radicand
    localparam int NST     = QW + NR + 4;        // pipeline stages
    localparam int ST_DIV  = 3;
    localparam int ST_ROOT = ST_DIV + QW;
    localparam int ST_OUT  = NST - 1;

    localparam logic [FRAC_BITS:0] MIN_VAL = {1'b1, {FRAC_BITS{1'b0}}};

    logic en;

    // stage control
    logic      valid_reg [NST];
    logic      valid_next [NST];
    arp_side_t side_reg [NST];
    arp_side_t side_next [NST];

    // datapath
    logic [MW-1:0]      mag_reg [NUM_LANES];
    logic [MW-1:0]      mag_next [NUM_LANES];
    logic [SW-1:0]      sq_reg [NUM_LANES];
    logic [SW-1:0]      sq_next [NUM_LANES];
    logic [SW-1:0]      num_reg [NUM_LANES];
    logic [SW-1:0]      num_next [NUM_LANES];
    logic [SW-1:0]      den_reg;
    logic [SW-1:0]      den_next;
    logic [SW-1:0]      div_den_reg [QW];
    logic [SW-1:0]      div_den_next [QW];
    logic [SW-1:0]      div_rem_reg [NUM_LANES][QW];
    logic [SW-1:0]      div_rem_next [NUM_LANES][QW];
    logic [QW-1:0]      div_q_reg [NUM_LANES][QW];
    logic [QW-1:0]      div_q_next [NUM_LANES][QW];
    logic [RW-1:0]      rt_rem_reg [NUM_LANES][NR];
    logic [RW-1:0]      rt_rem_next [NUM_LANES][NR];
    logic [NR-1:0]      rt_root_reg [NUM_LANES][NR];
    logic [NR-1:0]      rt_root_next [NUM_LANES][NR];
    logic [DW-1:0]      rt_d_reg [NUM_LANES][NR];
    logic [DW-1:0]      rt_d_next [NUM_LANES][NR];
    logic [FRAC_BITS:0] res_reg [NUM_LANES];
    logic [FRAC_BITS:0] res_next [NUM_LANES];

    // input selection
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    logic [MW-1:0] mag_z;
    logic          bad_axis;

    function automatic logic [MW-1:0] abs_mag(input logic [MW-1:0] v);
        return v[MW-1] ? (~v + MW'(1)) : v;
    endfunction

    // freeze everything while the output word waits
    assign en          = !valid_reg[ST_OUT] || coeff.ready;
    assign point.ready = en;

    assign mag_x = abs_mag(point.coord_x);
    assign mag_y = abs_mag(point.coord_y);
    assign mag_z = abs_mag(point.coord_z);

    always_comb
    begin
        bad_axis                = 1'b0;
        mag_next[LANE_COS]      = '0;
        mag_next[LANE_SIN]      = '0;
        side_next[0].cos_neg    = 1'b0;
        side_next[0].sin_neg    = 1'b0;
        case (point.action)
            AXIS_Z:
            begin
                mag_next[LANE_COS]   = mag_y;
                mag_next[LANE_SIN]   = mag_x;
                side_next[0].cos_neg = point.coord_y[MW-1];
                side_next[0].sin_neg = point.coord_x[MW-1];
            end
            AXIS_X:
            begin
                mag_next[LANE_COS]   = mag_y;
                mag_next[LANE_SIN]   = mag_z;
                side_next[0].cos_neg = point.coord_y[MW-1];
                side_next[0].sin_neg = !point.coord_z[MW-1];
            end
            AXIS_Y:
            begin
                mag_next[LANE_COS]   = mag_x;
                mag_next[LANE_SIN]   = mag_z;
                side_next[0].cos_neg = !point.coord_x[MW-1];
                side_next[0].sin_neg = !point.coord_z[MW-1];
            end
            default:
            begin
                bad_axis = 1'b1;
            end
        endcase
        side_next[0].degen = bad_axis ||
                             (mag_next[LANE_COS] == '0 && mag_next[LANE_SIN] == '0);
    end

    assign valid_next[0] = point.valid;

    for (genvar k = 1; k < NST; k++)
    begin : g_ctrl
        assign valid_next[k] = valid_reg[k-1];
        assign side_next[k]  = side_reg[k-1];
    end

    // shared denominator chain
    assign den_next = sq_reg[LANE_COS] + sq_reg[LANE_SIN];

    for (genvar j = 0; j < QW; j++)
    begin : g_den
        if (j == 0)
        begin : g_first
            assign div_den_next[j] = den_reg;
        end
        else
        begin : g_rest
            assign div_den_next[j] = div_den_reg[j-1];
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        assign sq_next[l]  = SW'(mag_reg[l]) * SW'(mag_reg[l]);
        assign num_next[l] = sq_reg[l];

        // restoring division of a*a * 2^(QW-1) by a*a + b*b, one quotient bit a stage
        for (genvar j = 0; j < QW; j++)
        begin : g_div
            logic [SW:0]    part;
            logic [SW:0]    dsub;
            logic [QW-1:0]  q_in;
            logic           ge;

            if (j == 0)
            begin : g_first
                assign part = {1'b0, num_reg[l]};
                assign dsub = {1'b0, den_reg};
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign part = {div_rem_reg[l][j-1], 1'b0};
                assign dsub = {1'b0, div_den_reg[j-1]};
                assign q_in = div_q_reg[l][j-1];
            end

            assign ge                 = part >= dsub;
            assign div_rem_next[l][j] = ge ? SW'(part - dsub) : SW'(part);
            assign div_q_next[l][j]   = {q_in[QW-2:0], ge};
        end

        // integer square root of the quotient, one root bit a stage
        for (genvar j = 0; j < NR; j++)
        begin : g_root
            logic [RW-1:0]  rem_in;
            logic [NR-1:0]  root_in;
            logic [DW-1:0]  d_in;
            logic [CAW-1:0] cand;
            logic [CAW-1:0] trial;
            logic           ge;

            if (j == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign d_in    = {1'b0, div_q_reg[l][QW-1]};
            end
            else
            begin : g_rest
                assign rem_in  = rt_rem_reg[l][j-1];
                assign root_in = rt_root_reg[l][j-1];
                assign d_in    = rt_d_reg[l][j-1];
            end

            assign cand               = {rem_in, d_in[DW-1 -: 2]};
            assign trial              = CAW'({root_in, 2'b01});
            assign ge                 = cand >= trial;
            assign rt_rem_next[l][j]  = ge ? RW'(cand - trial) : RW'(cand);
            assign rt_root_next[l][j] = {root_in[NR-2:0], ge};
            assign rt_d_next[l][j]    = {d_in[DW-3:0], 2'b00};
        end

        // round to nearest, saturate one, apply sign, zero degenerate words
        logic [NR:0]          inc;
        logic [FRAC_BITS:0]   half;
        logic [FRAC_BITS-1:0] mag;
        logic [FRAC_BITS:0]   val;
        logic                 neg;

        assign inc  = {1'b0, rt_root_reg[l][NR-1]} + (NR+1)'(1);
        assign half = inc[FRAC_BITS+1:1];
        assign mag  = half[FRAC_BITS] ? {FRAC_BITS{1'b1}} : half[FRAC_BITS-1:0];
        assign val  = {1'b0, mag};
        assign neg  = (l == LANE_COS) ? side_reg[ST_OUT-1].cos_neg
                                      : side_reg[ST_OUT-1].sin_neg;
        assign res_next[l] = side_reg[ST_OUT-1].degen ? '0 :
                             (neg ? (~val + (FRAC_BITS+1)'(1)) : val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg     <= side_next;
            mag_reg      <= mag_next;
            sq_reg       <= sq_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
            div_den_reg  <= div_den_next;
            div_rem_reg  <= div_rem_next;
            div_q_reg    <= div_q_next;
            rt_rem_reg   <= rt_rem_next;
            rt_root_reg  <= rt_root_next;
            rt_d_reg     <= rt_d_next;
            res_reg      <= res_next;
        end
    end

    assign coeff.valid      = valid_reg[ST_OUT];
    assign coeff.cos_value  = res_reg[LANE_COS];
    assign coeff.sin_value  = res_reg[LANE_SIN];
    assign coeff.degenerate = side_reg[ST_OUT].degen;

    `ARP_ASSERT(a_degen_zero, clk, rst_n, coeff.valid && coeff.degenerate |-> coeff.cos_value == '0 && coeff.sin_value == '0, "degenerate word carries nonzero coefficients")
    `ARP_ASSERT_NEVER(a_no_min, clk, rst_n, coeff.valid && (coeff.cos_value == MIN_VAL || coeff.sin_value == MIN_VAL), "coefficient escaped saturation")
    `ARP_ASSERT(a_nonzero, clk, rst_n, coeff.valid && !coeff.degenerate |-> coeff.cos_value != '0 || coeff.sin_value != '0, "rotation word with both coefficients zero")

endmodule

@@ sim/arp_coeff_checker.sv @@
// Scoreboard for the rotation coefficient block: predicts cos, sin and the degenerate flag
// for every accepted point and compares them with the result words in order.
// Depends on arp_pkg, arp_in_if and arp_out_if.
`timescale 1ns / 1ps

module arp_coeff_checker
    import arp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 15
)(
    input  logic clk,
    input  logic rst_n,
    arp_in_if    point,
    arp_out_if   coeff,
    output int   fail_count,
    output int   pending_results
);

    typedef struct packed {
        logic signed [FRAC_BITS:0] cos_v;
        logic signed [FRAC_BITS:0] sin_v;
        logic                      degen;
    } coeff_word_t;

    coeff_word_t expected_coeffs[$];
    int          errors  = 0;
    int          pending = 0;

    assign fail_count      = errors;
    assign pending_results = pending;

    function automatic logic [COORD_WIDTH:0] coord_magnitude(logic [COORD_WIDTH-1:0] v);
        if (v[COORD_WIDTH-1])
            return {1'b1, {COORD_WIDTH{1'b0}}} - {1'b0, v};
        return {1'b0, v};
    endfunction

    // Largest m with (2m-1)^2 * sum_sq <= a^2 * 2^(2F+2), i.e. a*2^F/sqrt(sum_sq)
    // rounded half away from zero; exactly one saturates.
    function automatic logic [FRAC_BITS:0] unit_ratio(logic [COORD_WIDTH:0] a,
                                                      logic [127:0] sum_sq);
        logic [127:0] aw;
        logic [127:0] target;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] t;
        aw     = a;
        target = (aw * aw) << (2 * FRAC_BITS + 2);
        lo     = 0;
        hi     = 128'd1 << FRAC_BITS;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t   = 2 * mid - 1;
            if (t * t * sum_sq <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo == (128'd1 << FRAC_BITS))
            lo = lo - 1;
        return lo[FRAC_BITS:0];
    endfunction

    function automatic coeff_word_t predict_rotation(logic [ACTION_W-1:0]    act,
                                                     logic [COORD_WIDTH-1:0] x,
                                                     logic [COORD_WIDTH-1:0] y,
                                                     logic [COORD_WIDTH-1:0] z);
        logic [COORD_WIDTH:0] mx;
        logic [COORD_WIDTH:0] my;
        logic [COORD_WIDTH:0] mz;
        logic [COORD_WIDTH:0] c_mag;
        logic [COORD_WIDTH:0] s_mag;
        logic                 c_neg;
        logic                 s_neg;
        logic                 axis_ok;
        logic [127:0]         sum_sq;
        logic [FRAC_BITS:0]   c_frac;
        logic [FRAC_BITS:0]   s_frac;
        coeff_word_t          w;
        mx      = coord_magnitude(x);
        my      = coord_magnitude(y);
        mz      = coord_magnitude(z);
        axis_ok = 1'b1;
        c_mag   = '0;
        s_mag   = '0;
        c_neg   = 1'b0;
        s_neg   = 1'b0;
        case (act)
            AXIS_Z:
            begin
                c_mag = my;  c_neg = y[COORD_WIDTH-1];
                s_mag = mx;  s_neg = x[COORD_WIDTH-1];
            end
            AXIS_X:
            begin
                c_mag = my;  c_neg = y[COORD_WIDTH-1];
                s_mag = mz;  s_neg = !z[COORD_WIDTH-1];
            end
            AXIS_Y:
            begin
                c_mag = mx;  c_neg = !x[COORD_WIDTH-1];
                s_mag = mz;  s_neg = !z[COORD_WIDTH-1];
            end
            default:
                axis_ok = 1'b0;
        endcase
        w       = '0;
        w.degen = 1'b1;
        if (axis_ok && (c_mag != 0 || s_mag != 0))
        begin
            sum_sq  = 128'(c_mag) * 128'(c_mag) + 128'(s_mag) * 128'(s_mag);
            c_frac  = unit_ratio(c_mag, sum_sq);
            s_frac  = unit_ratio(s_mag, sum_sq);
            w.cos_v = c_neg ? -c_frac : c_frac;
            w.sin_v = s_neg ? -s_frac : s_frac;
            w.degen = 1'b0;
        end
        return w;
    endfunction

    always @(posedge clk)
    begin
        coeff_word_t want;
        coeff_word_t got;
        if (rst_n)
        begin
            if (point.valid && point.ready)
                expected_coeffs.push_back(predict_rotation(point.action, point.coord_x,
                                                           point.coord_y, point.coord_z));
            if (coeff.valid && coeff.ready)
            begin
                got = '{coeff.cos_value, coeff.sin_value, coeff.degenerate};
                if (expected_coeffs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word cos %0d sin %0d degenerate %0b", $time,
                             got.cos_v, got.sin_v, got.degen);
                end
                else
                begin
                    want = expected_coeffs.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected cos %0d sin %0d degenerate %0b, got cos %0d sin %0d degenerate %0b",
                                 $time, want.cos_v, want.sin_v, want.degen,
                                 got.cos_v, got.sin_v, got.degen);
                    end
                end
            end
            pending = expected_coeffs.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Top of the rotation coefficient testbench: clock, reset, point stimulus, output stalls.
// Depends on arp_pkg, the channel interfaces, axis_rotation_from_point and arp_coeff_checker.
`timescale 1ns / 1ps

module tb;
    import arp_pkg::*;

    localparam int COORD_WIDTH   = 16;
    localparam int FRAC_BITS     = 15;
    localparam int PIPE_LATENCY  = 3 * FRAC_BITS + 9;
    localparam int RANDOM_POINTS = 1100;
    localparam int CYCLE_LIMIT   = 300000;

    // Axis code with no rotation; the block flags it as degenerate.
    localparam logic [ACTION_W-1:0] AXIS_NONE = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    int       fail_count;
    int       pending_results;
    int       burst_left = 0;
    int       cycles     = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    arp_in_if  #(.COORD_WIDTH(COORD_WIDTH)) point ();
    arp_out_if #(.FRAC_BITS(FRAC_BITS))     coeff ();

    axis_rotation_from_point #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .point(point),
        .coeff(coeff)
    );

    arp_coeff_checker #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) i_coeff_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .point          (point),
        .coeff          (coeff),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output stalls: switch at random between stall patterns.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     coeff.ready <= 1'b1;
            RX_LIGHT:    coeff.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    coeff.ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: coeff.ready <= ((rx_left % 7) < 4);
        endcase
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_point(input logic [ACTION_W-1:0]    act,
                              input logic [COORD_WIDTH-1:0] x,
                              input logic [COORD_WIDTH-1:0] y,
                              input logic [COORD_WIDTH-1:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                point.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        point.valid   <= 1'b1;
        point.action  <= act;
        point.coord_x <= x;
        point.coord_y <= y;
        point.coord_z <= z;
        do
            @(posedge clk);
        while (!point.ready);
        @(negedge clk);
    endtask

    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        logic [COORD_WIDTH-1:0] v;
        case ($urandom_range(0, 7))
            0: v = COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            2:
            begin
                v = COORD_WIDTH'(1) << $urandom_range(0, COORD_WIDTH - 1);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = COORD_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [ACTION_W-1:0] pick_axis();
        case ($urandom_range(0, 15))
            0:       return AXIS_NONE;
            1, 2, 3, 4, 5: return AXIS_Z;
            6, 7, 8, 9, 10: return AXIS_X;
            default: return AXIS_Y;
        endcase
    endfunction

    initial
    begin
        logic [ACTION_W-1:0] act;
        point.valid   = 1'b0;
        point.action  = '0;
        point.coord_x = '0;
        point.coord_y = '0;
        point.coord_z = '0;
        coeff.ready   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 3; i++)
        begin
            act = (i == 0) ? AXIS_Z : (i == 1) ? AXIS_X : AXIS_Y;
            send_point(act, 16'h0000, 16'h0000, 16'h0000);
            send_point(act, 16'h8000, 16'h8000, 16'h8000);
            send_point(act, 16'h7FFF, 16'h7FFF, 16'h7FFF);
            send_point(act, 16'h8000, 16'h0001, 16'hFFFF);
            send_point(act, 16'h0001, 16'h0000, 16'h8000);
            // Only the unused coordinate is set: degenerate for the Z axis.
            send_point(act, 16'h0000, 16'h0000, 16'h04D2);
            send_point(act, 16'h0003, 16'h0004, 16'hFFFB);
        end
        send_point(AXIS_NONE, 16'h0000, 16'h0000, 16'h0000);
        send_point(AXIS_NONE, 16'h1234, 16'h8765, 16'h7FFF);

        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            // Drain the pipeline once with the input held off.
            if (n == RANDOM_POINTS / 2)
            begin
                point.valid <= 1'b0;
                wait (pending_results == 0);
                @(negedge clk);
            end
            send_point(pick_axis(), pick_coord(), pick_coord(), pick_coord());
        end
        point.valid <= 1'b0;

        wait (pending_results == 0);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/arp_pkg.sv
hw/rtl/arp_in_if.sv
hw/rtl/arp_out_if.sv
hw/rtl/axis_rotation_from_point.sv
sim/arp_coeff_checker.sv
sim/tb.sv
